FILE: hdl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types, constants and helpers of the flow pulse totalizer.
// ----------------------------------------------------------------------------
package fpt_pkg;

  localparam int unsigned TICK_RATE = 32768;

  localparam longint unsigned TICKS_SEC  = longint'(TICK_RATE);
  localparam longint unsigned TICKS_MIN  = longint'(TICK_RATE) * 60;
  localparam longint unsigned TICKS_HOUR = longint'(TICK_RATE) * 3600;
  localparam longint unsigned TICKS_DAY  = longint'(TICK_RATE) * 86400;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned MILLION   = 1000000;
  localparam int unsigned MIL_W     = $clog2(MILLION + 1);
  localparam int unsigned UTW       = $clog2(TICKS_DAY + 1);
  localparam int unsigned RNUM_W    = WIN_W + UTW;
  localparam int unsigned DEN_W     = WIN_W + VAL_W;
  localparam int unsigned MUL_A_W   = (RNUM_W > DEN_W) ? RNUM_W : DEN_W;
  localparam int unsigned DVD_W     = MUL_A_W + MIL_W;
  localparam int unsigned CNT_W     = $clog2(DVD_W);
  localparam logic [VAL_W-1:0] CAL_RESET = VAL_W'(1000);

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned CFG_ADDR_W  = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CAL_FACTOR = 2'd0,
    REG_RATE_UNIT  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    UNIT_SEC  = 2'd0,
    UNIT_MIN  = 2'd1,
    UNIT_HOUR = 2'd2,
    UNIT_DAY  = 2'd3
  } rate_unit_e;

  typedef enum logic [1:0] {
    OP_PART  = 2'd0,
    OP_GRAND = 2'd1,
    OP_RATE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_DEN  = 2'd1,
    MUL_RNUM = 2'd2,
    MUL_NUM  = 2'd3
  } mul_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DEN,
    S_MUL_RNUM,
    S_MUL_NUM,
    S_DIV,
    S_STORE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load;
    mul_op_e mul_op;
    op_e     op;
    logic    div_start;
    logic    div_en;
    logic    store;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  function automatic logic [UTW-1:0] unit_ticks(input rate_unit_e unit);
    logic [UTW-1:0] t;
    case (unit)
      UNIT_SEC:  t = UTW'(TICKS_SEC);
      UNIT_MIN:  t = UTW'(TICKS_MIN);
      UNIT_HOUR: t = UTW'(TICKS_HOUR);
      UNIT_DAY:  t = UTW'(TICKS_DAY);
      default:   t = UTW'(TICKS_SEC);
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/flow_pulse_totalizer_top.sv
// ----------------------------------------------------------------------------
// flow_pulse_totalizer_top
// Flow meter pulse totalizer with volume and rate in six-decimal fixed point.
//
//   Channel  Direction  Payload
//   s_axis   in         new_pulses, window_pulses, window_ticks, clears
//   m_axis   out        partial_volume, grand_volume, flow_rate, rate_error
//   cfg      in         index 0 cal_factor, index 1 rate_time_unit
//
// An item runs through a load, two setup multiplies and three bit-serial
// divisions of 68 steps each in one shared divider, each after a multiply.
// One item is in work at a time; s_axis is ready only when the sequencer
// idles. A finished result waits in the output register; a new item may be
// accepted meanwhile. Reset clears both pulse totals and loads config
// defaults.
// ----------------------------------------------------------------------------
module flow_pulse_totalizer_top import fpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] new_pulses, [47:32] window_pulses, [63:48] window_ticks,
  // [64] clear_partial, [65] clear_grand
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] partial_volume, [63:32] grand_volume, [95:64] flow_rate,
  // [96] rate_error
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [VAL_W-1:0]       cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  fpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fpt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .new_pulses_i    (s_axis_tdata[31:0]),
    .window_pulses_i (s_axis_tdata[47:32]),
    .window_ticks_i  (s_axis_tdata[63:48]),
    .clear_partial_i (s_axis_tdata[64]),
    .clear_grand_i   (s_axis_tdata[65]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_data_o      (m_axis_tdata)
  );

endmodule

FILE: hdl/fpt_datapath.sv
// ----------------------------------------------------------------------------
// fpt_datapath
// Config registers, pulse counters, shared multiplier, bit-serial divider
// and result registers.
// ----------------------------------------------------------------------------
module fpt_datapath import fpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [VAL_W-1:0]       cfg_data_i,
  input  logic [VAL_W-1:0]       new_pulses_i,
  input  logic [WIN_W-1:0]       window_pulses_i,
  input  logic [WIN_W-1:0]       window_ticks_i,
  input  logic                   clear_partial_i,
  input  logic                   clear_grand_i,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [VAL_W-1:0]   cal_q;
  rate_unit_e         unit_q;
  logic [VAL_W-1:0]   part_q, grand_q;
  logic [WIN_W-1:0]   dp_q, dt_q;
  logic               err_q;
  logic [DEN_W-1:0]   den_q;
  logic [RNUM_W-1:0]  rnum_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [VAL_W-1:0]   quo_q;
  logic               ovf_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [VAL_W-1:0]   res_part_q, res_grand_q, res_rate_q, res_val;
  logic [OUT_TDATA_W-1:0] out_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MIL_W-1:0]   mul_b;
  logic [DVD_W-1:0]   prod;
  logic [DEN_W-1:0]   divisor;
  logic [DEN_W:0]     trial, diff;
  logic               ge;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_DEN: begin
        mul_a = MUL_A_W'(cal_q);
        mul_b = MIL_W'(dt_q);
      end
      MUL_RNUM: begin
        mul_a = MUL_A_W'(unit_ticks(unit_q));
        mul_b = MIL_W'(dp_q);
      end
      MUL_NUM: begin
        mul_b = MIL_W'(MILLION);
        case (cmd_i.op)
          OP_PART:  mul_a = MUL_A_W'(part_q);
          OP_GRAND: mul_a = MUL_A_W'(grand_q);
          OP_RATE:  mul_a = MUL_A_W'(rnum_q);
          default:  mul_a = '0;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = DVD_W'(mul_a) * DVD_W'(mul_b);

  assign divisor = (cmd_i.op == OP_RATE) ? den_q : DEN_W'(cal_q);
  assign trial   = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};
  assign rem_d   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign res_val = ovf_q ? '1 : quo_q;

  assign status_o.div_done = (cnt_q == CNT_W'(DVD_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q   <= CAL_RESET;
      unit_q  <= UNIT_SEC;
      part_q  <= '0;
      grand_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_addr_i == REG_CAL_FACTOR) begin
        cal_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_addr_i == REG_RATE_UNIT) begin
        unit_q <= rate_unit_e'(cfg_data_i[1:0]);
      end
      if (cmd_i.load) begin
        part_q  <= (clear_partial_i ? '0 : part_q) + new_pulses_i;
        grand_q <= (clear_grand_i ? '0 : grand_q) + new_pulses_i;
      end
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dp_q  <= window_pulses_i;
      dt_q  <= window_ticks_i;
      err_q <= (window_ticks_i == '0);
    end
    if (cmd_i.mul_op == MUL_DEN) begin
      den_q <= prod[DEN_W-1:0];
    end
    if (cmd_i.mul_op == MUL_RNUM) begin
      rnum_q <= prod[RNUM_W-1:0];
    end
    if (cmd_i.mul_op == MUL_NUM) begin
      dvd_q <= prod;
    end else if (cmd_i.div_en) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.div_en) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[VAL_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[VAL_W-1];
    end
    if (cmd_i.store) begin
      case (cmd_i.op)
        OP_PART:  res_part_q  <= res_val;
        OP_GRAND: res_grand_q <= res_val;
        OP_RATE:  res_rate_q  <= res_val;
        default:  res_rate_q  <= res_val;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= {7'b0, err_q, res_rate_q, res_grand_q, res_part_q};
    end
  end

  assign out_data_o = out_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_en) && !$past(cfg_valid_i) && divisor != '0 |-> rem_q < divisor)
    else $error("divider remainder not below divisor");

endmodule

FILE: hdl/fpt_ctrl.sv
// ----------------------------------------------------------------------------
// fpt_ctrl
// Sequencer: load, two setup multiplies, then multiply and divide for the
// partial volume, grand volume and rate, then hand off to the output.
// ----------------------------------------------------------------------------
module fpt_ctrl import fpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PART;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '{load: 1'b0, mul_op: MUL_NONE, op: op_q, div_start: 1'b0,
                    div_en: 1'b0, store: 1'b0, out_load: 1'b0};
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL_DEN;
        end
      end
      S_MUL_DEN: begin
        cmd_o.mul_op = MUL_DEN;
        state_d      = S_MUL_RNUM;
      end
      S_MUL_RNUM: begin
        cmd_o.mul_op = MUL_RNUM;
        op_d         = OP_PART;
        state_d      = S_MUL_NUM;
      end
      S_MUL_NUM: begin
        cmd_o.mul_op    = MUL_NUM;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (status_i.div_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        case (op_q)
          OP_PART: begin
            op_d    = OP_GRAND;
            state_d = S_MUL_NUM;
          end
          OP_GRAND: begin
            op_d    = OP_RATE;
            state_d = S_MUL_NUM;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_MUL_DEN)
    else $error("accepted item did not start the sequence");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && status_i.div_done |=> state_q == S_STORE)
    else $error("divider finish not followed by store");

  a_finish_hands_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && (!out_valid_q || out_ready_i)
    |=> out_valid_q && state_q == S_IDLE)
    else $error("result not handed to output register");

endmodule
